// ===== sv/sceu_pkg.sv =====
package sceu_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int LINK_W    = EDGE_W + 1;
    localparam int CNT_W     = NODE_W + 1;
    localparam int FRAME_W   = NODE_W + LINK_W;

    // The null link has only its top bit set: it is one past the last edge.
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_EDGES);

    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_RUN = 1'b1;

    typedef struct packed {
        logic        func;
        logic [10:0] src_node;
        logic [10:0] dst_node;
    } t_in_item;

    typedef struct packed {
        logic [10:0] edges_needed;
        logic [10:0] component_count;
        logic        dropped_edges;
    } t_out_item;

    typedef enum logic [22:0] {
        ST_IDLE     = 23'h000001,
        ST_ADD      = 23'h000002,
        ST_ROOT     = 23'h000004,
        ST_ROOT_CHK = 23'h000008,
        ST_PUSH     = 23'h000010,
        ST_LOOP     = 23'h000020,
        ST_EDGE_RD  = 23'h000040,
        ST_EDGE_CHK = 23'h000080,
        ST_POP_CHK  = 23'h000100,
        ST_SCC_RD   = 23'h000200,
        ST_SCC_WR   = 23'h000400,
        ST_PARENT   = 23'h000800,
        ST_PAR_RD   = 23'h001000,
        ST_PAR_UPD  = 23'h002000,
        ST_ESCAN    = 23'h004000,
        ST_EU       = 23'h008000,
        ST_EW       = 23'h010000,
        ST_ECMP     = 23'h020000,
        ST_CNT      = 23'h040000,
        ST_CNT_ACC  = 23'h080000,
        ST_DONE     = 23'h100000,
        ST_CLR      = 23'h200000,
        ST_SPARE    = 23'h400000
    } t_state;

endpackage

// ===== sv/scc_augment_edge_count_unit.sv =====
// Channel | Direction | Handshake                        | Payload
// in      | input     | i_in_valid / o_in_ready          | i_in_data  (t_in_item)
// out     | output    | o_out_valid / i_out_ready        | o_out_data (t_out_item)
// cfg     | input     | i_cfg_valid / o_cfg_ready        | i_cfg_data (node_count)
//
// An edge item reads the list head of its source node, then writes the edge
// and relinks the head. A dropped edge only sets the drop flag.
// A run item does the component search over nodes and edges, then makes the
// cross-component marks for each stored edge, then the counts for each
// component, then a sweep over all 1024 entries empties the node memories.
// That sweep also runs after reset, and the input is not ready until it ends.
// All work is bounded by one read port per node or edge memory.
// The result sits in an output register; a stalled output holds the block in
// its final state only while an earlier result has not yet been taken.
module scc_augment_edge_count_unit
    import sceu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    // Edge store: target, origin and next link of each edge.
    logic [NODE_W-1:0]  m_tgt  [MAX_EDGES];
    logic [NODE_W-1:0]  m_org  [MAX_EDGES];
    logic [LINK_W-1:0]  m_link [MAX_EDGES];
    // Node store: list head, search numbers, stacks and component marks.
    logic [LINK_W-1:0]  m_head [MAX_NODES];
    logic [CNT_W-1:0]   m_vis  [MAX_NODES];
    logic [CNT_W-1:0]   m_low  [MAX_NODES];
    logic               m_onst [MAX_NODES];
    logic [NODE_W-1:0]  m_cid  [MAX_NODES];
    logic [NODE_W-1:0]  m_nstk [MAX_NODES];
    logic [FRAME_W-1:0] m_cstk [MAX_NODES];
    logic               m_hin  [MAX_NODES];
    logic               m_hout [MAX_NODES];

    // Registered read data.
    logic [NODE_W-1:0]  r_tgt_rd, r_org_rd, r_cid_rd, r_nstk_rd;
    logic [LINK_W-1:0]  r_link_rd, r_head_rd;
    logic [CNT_W-1:0]   r_vis_rd, r_low_rd;
    logic               r_onst_rd, r_hin_rd, r_hout_rd;
    logic [FRAME_W-1:0] r_cstk_rd;

    // Memory control.
    logic               edge_we;
    logic [EDGE_W-1:0]  edge_wa, edge_ra;
    logic [NODE_W-1:0]  tgt_wd, org_wd;
    logic [LINK_W-1:0]  link_wd, head_wd;
    logic               head_we, vis_we, low_we, onst_we, cid_we, nstk_we, cstk_we;
    logic               hin_we, hout_we;
    logic [NODE_W-1:0]  head_wa, head_ra, vis_wa, vis_ra, low_wa, low_ra;
    logic [NODE_W-1:0]  onst_wa, onst_ra, cid_wa, cid_ra, nstk_wa, nstk_ra;
    logic [NODE_W-1:0]  cstk_wa, cstk_ra, hin_wa, hout_wa, flag_ra;
    logic [CNT_W-1:0]   vis_wd, low_wd;
    logic               onst_wd, flag_wd;
    logic [NODE_W-1:0]  cid_wd, nstk_wd;
    logic [FRAME_W-1:0] cstk_wd;

    // Sequencer state and datapath registers.
    t_state             r_state, n_state;
    logic [10:0]        r_node_count, n_node_count;
    logic [LINK_W-1:0]  r_et, n_et;
    logic               r_drop, n_drop;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_counter, n_counter;
    logic [CNT_W-1:0]   r_comps, n_comps;
    logic [CNT_W-1:0]   r_nsp, n_nsp;
    logic [CNT_W-1:0]   r_csp, n_csp;
    logic [CNT_W-1:0]   r_root, n_root;
    logic [NODE_W-1:0]  r_v, n_v;
    logic [LINK_W-1:0]  r_e, n_e;
    logic [NODE_W-1:0]  r_w, n_w;
    logic [NODE_W-1:0]  r_u, n_u;
    logic [NODE_W-1:0]  r_cu, n_cu;
    logic [CNT_W-1:0]   r_lowv, n_lowv;
    logic [CNT_W-1:0]   r_c, n_c;
    logic [CNT_W-1:0]   r_no_in, n_no_in;
    logic [CNT_W-1:0]   r_no_out, n_no_out;
    logic [CNT_W-1:0]   r_clr, n_clr;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [CNT_W-1:0]   neff;
    logic               in_acc;
    logic               bad_edge;
    logic [CNT_W-1:0]   src_m1, dst_m1, nsp_m1, csp_m1, cnt_p1;
    logic [CNT_W-1:0]   worst;

    // A node count above the capacity saturates to it.
    assign neff   = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;
    assign in_acc = i_in_valid && o_in_ready;
    assign src_m1 = i_in_data.src_node - 11'd1;
    assign dst_m1 = i_in_data.dst_node - 11'd1;
    assign nsp_m1 = r_nsp - CNT_W'(1);
    assign csp_m1 = r_csp - CNT_W'(1);
    assign cnt_p1 = r_counter + CNT_W'(1);
    assign worst  = (r_no_in > r_no_out) ? r_no_in : r_no_out;
    assign bad_edge = (i_in_data.src_node == 11'd0) || (i_in_data.dst_node == 11'd0)
                   || (i_in_data.src_node > neff) || (i_in_data.dst_node > neff)
                   || r_et[EDGE_W];

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_node_count = r_node_count;
        n_et         = r_et;
        n_drop       = r_drop;
        n_n          = r_n;
        n_counter    = r_counter;
        n_comps      = r_comps;
        n_nsp        = r_nsp;
        n_csp        = r_csp;
        n_root       = r_root;
        n_v          = r_v;
        n_e          = r_e;
        n_w          = r_w;
        n_u          = r_u;
        n_cu         = r_cu;
        n_lowv       = r_lowv;
        n_c          = r_c;
        n_no_in      = r_no_in;
        n_no_out     = r_no_out;
        n_clr        = r_clr;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;

        edge_we = 1'b0;  edge_wa = r_et[EDGE_W-1:0];  edge_ra = r_e[EDGE_W-1:0];
        tgt_wd  = r_w;   org_wd  = r_u;               link_wd = r_head_rd;
        head_we = 1'b0;  head_wa = r_u;  head_ra = r_w;  head_wd = r_et;
        vis_we  = 1'b0;  vis_wa  = r_w;  vis_ra  = r_w;  vis_wd  = cnt_p1;
        low_we  = 1'b0;  low_wa  = r_w;  low_ra  = r_v;  low_wd  = cnt_p1;
        onst_we = 1'b0;  onst_wa = r_w;  onst_ra = r_w;  onst_wd = 1'b1;
        cid_we  = 1'b0;  cid_wa  = r_nstk_rd;  cid_ra = r_w;  cid_wd = r_comps[NODE_W-1:0];
        nstk_we = 1'b0;  nstk_wa = r_nsp[NODE_W-1:0];  nstk_ra = nsp_m1[NODE_W-1:0];
        nstk_wd = r_w;
        cstk_we = 1'b0;  cstk_wa = csp_m1[NODE_W-1:0];  cstk_ra = csp_m1[NODE_W-1:0];
        cstk_wd = {r_v, r_link_rd};
        hin_we  = 1'b0;  hin_wa  = r_cid_rd;
        hout_we = 1'b0;  hout_wa = r_cu;
        flag_ra = r_c[NODE_W-1:0];  flag_wd = 1'b1;

        if (i_cfg_valid) begin
            n_node_count = i_cfg_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.func == FUNC_RUN) begin
                        n_n       = neff;
                        n_counter = '0;
                        n_comps   = '0;
                        n_nsp     = '0;
                        n_csp     = '0;
                        n_root    = '0;
                        n_state   = ST_ROOT;
                    end else if (bad_edge) begin
                        n_drop = 1'b1;
                    end else begin
                        n_u     = src_m1[NODE_W-1:0];
                        n_w     = dst_m1[NODE_W-1:0];
                        head_ra = src_m1[NODE_W-1:0];
                        n_state = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                // Prepend the edge to its source node's list.
                edge_we = 1'b1;
                head_we = 1'b1;
                n_et    = r_et + LINK_W'(1);
                n_state = ST_IDLE;
            end
            ST_ROOT: begin
                vis_ra = r_root[NODE_W-1:0];
                if (r_root == r_n) begin
                    n_e     = '0;
                    n_state = ST_ESCAN;
                end else begin
                    n_state = ST_ROOT_CHK;
                end
            end
            ST_ROOT_CHK: begin
                if (r_vis_rd != '0) begin
                    n_root  = r_root + CNT_W'(1);
                    n_state = ST_ROOT;
                end else begin
                    n_counter = cnt_p1;
                    vis_we  = 1'b1;  vis_wa  = r_root[NODE_W-1:0];
                    low_we  = 1'b1;  low_wa  = r_root[NODE_W-1:0];
                    onst_we = 1'b1;  onst_wa = r_root[NODE_W-1:0];
                    nstk_we = 1'b1;  nstk_wd = r_root[NODE_W-1:0];
                    n_nsp   = r_nsp + CNT_W'(1);
                    head_ra = r_root[NODE_W-1:0];
                    n_w     = r_root[NODE_W-1:0];
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cstk_we = 1'b1;
                cstk_wa = r_csp[NODE_W-1:0];
                cstk_wd = {r_w, r_head_rd};
                n_csp   = r_csp + CNT_W'(1);
                n_v     = r_w;
                n_e     = r_head_rd;
                n_state = ST_LOOP;
            end
            ST_LOOP: begin
                if (!r_e[EDGE_W]) begin
                    n_state = ST_EDGE_RD;
                end else begin
                    // Out of edges: the frame returns.
                    vis_ra  = r_v;
                    low_ra  = r_v;
                    n_csp   = csp_m1;
                    n_state = ST_POP_CHK;
                end
            end
            ST_EDGE_RD: begin
                n_e     = r_link_rd;
                cstk_we = 1'b1;
                if ({1'b0, r_tgt_rd} >= r_n) begin
                    n_state = ST_LOOP;
                end else begin
                    n_w     = r_tgt_rd;
                    vis_ra  = r_tgt_rd;
                    onst_ra = r_tgt_rd;
                    n_state = ST_EDGE_CHK;
                end
            end
            ST_EDGE_CHK: begin
                if (r_vis_rd == '0) begin
                    n_counter = cnt_p1;
                    vis_we  = 1'b1;
                    low_we  = 1'b1;
                    onst_we = 1'b1;
                    nstk_we = 1'b1;
                    n_nsp   = r_nsp + CNT_W'(1);
                    n_state = ST_PUSH;
                end else begin
                    if (r_onst_rd && (r_vis_rd < r_low_rd)) begin
                        low_we = 1'b1;
                        low_wa = r_v;
                        low_wd = r_vis_rd;
                    end
                    n_state = ST_LOOP;
                end
            end
            ST_POP_CHK: begin
                n_lowv  = r_low_rd;
                n_state = (r_low_rd == r_vis_rd) ? ST_SCC_RD : ST_PARENT;
            end
            ST_SCC_RD: begin
                n_state = ST_SCC_WR;
            end
            ST_SCC_WR: begin
                cid_we  = 1'b1;
                onst_we = 1'b1;
                onst_wa = r_nstk_rd;
                onst_wd = 1'b0;
                n_nsp   = nsp_m1;
                if (r_nstk_rd == r_v) begin
                    n_comps = r_comps + CNT_W'(1);
                    n_state = ST_PARENT;
                end else begin
                    n_state = ST_SCC_RD;
                end
            end
            ST_PARENT: begin
                if (r_csp == '0) begin
                    n_root  = r_root + CNT_W'(1);
                    n_state = ST_ROOT;
                end else begin
                    n_state = ST_PAR_RD;
                end
            end
            ST_PAR_RD: begin
                n_v     = r_cstk_rd[FRAME_W-1:LINK_W];
                n_e     = r_cstk_rd[LINK_W-1:0];
                low_ra  = r_cstk_rd[FRAME_W-1:LINK_W];
                n_state = ST_PAR_UPD;
            end
            ST_PAR_UPD: begin
                if (r_lowv < r_low_rd) begin
                    low_we = 1'b1;
                    low_wa = r_v;
                    low_wd = r_lowv;
                end
                n_state = ST_LOOP;
            end
            ST_ESCAN: begin
                if (r_e == r_et) begin
                    n_c      = '0;
                    n_no_in  = '0;
                    n_no_out = '0;
                    n_state  = ST_CNT;
                end else begin
                    n_state = ST_EU;
                end
            end
            ST_EU: begin
                if (({1'b0, r_org_rd} >= r_n) || ({1'b0, r_tgt_rd} >= r_n)) begin
                    n_e     = r_e + LINK_W'(1);
                    n_state = ST_ESCAN;
                end else begin
                    n_w     = r_tgt_rd;
                    cid_ra  = r_org_rd;
                    n_state = ST_EW;
                end
            end
            ST_EW: begin
                n_cu    = r_cid_rd;
                n_state = ST_ECMP;
            end
            ST_ECMP: begin
                if (r_cid_rd != r_cu) begin
                    hin_we  = 1'b1;
                    hout_we = 1'b1;
                end
                n_e     = r_e + LINK_W'(1);
                n_state = ST_ESCAN;
            end
            ST_CNT: begin
                n_state = (r_c == r_comps) ? ST_DONE : ST_CNT_ACC;
            end
            ST_CNT_ACC: begin
                n_no_in  = r_no_in + CNT_W'(!r_hin_rd);
                n_no_out = r_no_out + CNT_W'(!r_hout_rd);
                n_c      = r_c + CNT_W'(1);
                n_state  = ST_CNT;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.edges_needed    = (r_comps <= CNT_W'(1)) ? '0 : worst;
                    n_out.component_count = r_comps;
                    n_out.dropped_edges   = r_drop;
                    n_out_valid = 1'b1;
                    n_et        = '0;
                    n_drop      = 1'b0;
                    n_clr       = '0;
                    n_state     = ST_CLR;
                end
            end
            ST_CLR: begin
                head_we = 1'b1;  head_wa = r_clr[NODE_W-1:0];  head_wd = LINK_NULL;
                vis_we  = 1'b1;  vis_wa  = r_clr[NODE_W-1:0];  vis_wd  = '0;
                onst_we = 1'b1;  onst_wa = r_clr[NODE_W-1:0];  onst_wd = 1'b0;
                hin_we  = 1'b1;  hin_wa  = r_clr[NODE_W-1:0];
                hout_we = 1'b1;  hout_wa = r_clr[NODE_W-1:0];
                flag_wd = 1'b0;
                n_clr   = r_clr + CNT_W'(1);
                if (r_clr == CNT_W'(MAX_NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_clr        <= '0;
            r_node_count <= 11'd1;
            r_et         <= '0;
            r_drop       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_node_count <= n_node_count;
            r_et         <= n_et;
            r_drop       <= n_drop;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_counter <= n_counter;
        r_comps  <= n_comps;
        r_nsp    <= n_nsp;
        r_csp    <= n_csp;
        r_root   <= n_root;
        r_v      <= n_v;
        r_e      <= n_e;
        r_w      <= n_w;
        r_u      <= n_u;
        r_cu     <= n_cu;
        r_lowv   <= n_lowv;
        r_c      <= n_c;
        r_no_in  <= n_no_in;
        r_no_out <= n_no_out;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            m_tgt[edge_wa]  <= tgt_wd;
            m_org[edge_wa]  <= org_wd;
            m_link[edge_wa] <= link_wd;
        end
        r_tgt_rd  <= m_tgt[edge_ra];
        r_org_rd  <= m_org[edge_ra];
        r_link_rd <= m_link[edge_ra];
    end

    always_ff @(posedge i_clk) begin
        if (head_we) m_head[head_wa] <= head_wd;
        if (vis_we)  m_vis[vis_wa]   <= vis_wd;
        if (low_we)  m_low[low_wa]   <= low_wd;
        if (onst_we) m_onst[onst_wa] <= onst_wd;
        if (cid_we)  m_cid[cid_wa]   <= cid_wd;
        if (nstk_we) m_nstk[nstk_wa] <= nstk_wd;
        if (cstk_we) m_cstk[cstk_wa] <= cstk_wd;
        if (hin_we)  m_hin[hin_wa]   <= flag_wd;
        if (hout_we) m_hout[hout_wa] <= flag_wd;
        r_head_rd <= m_head[head_ra];
        r_vis_rd  <= m_vis[vis_ra];
        r_low_rd  <= m_low[low_ra];
        r_onst_rd <= m_onst[onst_ra];
        r_cid_rd  <= m_cid[cid_ra];
        r_nstk_rd <= m_nstk[nstk_ra];
        r_cstk_rd <= m_cstk[cstk_ra];
        r_hin_rd  <= m_hin[flag_ra];
        r_hout_rd <= m_hout[flag_ra];
    end

endmodule

// ===== sv/sceu_checker.sv =====
module sceu_checker
    import sceu_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in_item    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_data,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [10:0] i_cfg_data
);

    // A result item is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result item dropped or changed while stalled");

    // A run item keeps the input closed on the next cycle.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.func == FUNC_RUN) |=> !o_in_ready)
        else $error("input ready right after a run item");

    // The augmentation count never exceeds the component count.
    a_need_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.edges_needed <= o_out_data.component_count)
        else $error("edges needed above component count");

    // A single component needs no added edge.
    a_one_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.component_count <= 11'd1)
            |-> o_out_data.edges_needed == 11'd0)
        else $error("edges needed for a single component");

    // Configuration writes are always taken.
    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind scc_augment_edge_count_unit sceu_checker u_sceu_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sceu_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    // The block sweeps its node memories after a run and after reset, so a
    // settle time a little over that sweep covers any work still in flight.
    localparam int SETTLE_CYCLES = 1200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;

    scc_augment_edge_count_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Items waiting to be sent, and the answers expected for accepted runs.
    t_in_item  send_queue[$];
    t_out_item answer_queue[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        items_queued = 0;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the graph store and configuration.
    // ------------------------------------------------------------------
    logic [10:0] nodes_cfg;
    int          arc_to[MAX_EDGES];
    int          arc_from[MAX_EDGES];
    int          arc_next[MAX_EDGES];
    int          adj_head[MAX_NODES];
    int          disc[MAX_NODES];
    int          low[MAX_NODES];
    int          comp_of[MAX_NODES];
    bit          stacked[MAX_NODES];
    int          tarjan_stack[MAX_NODES];
    int          frame_node[MAX_NODES];
    int          frame_arc[MAX_NODES];
    bit          comp_in[MAX_NODES];
    bit          comp_out[MAX_NODES];
    int          arc_total;
    bit          arc_dropped;

    function automatic int live_nodes();
        return (nodes_cfg > MAX_NODES) ? MAX_NODES : int'(nodes_cfg);
    endfunction

    function automatic void forget_graph();
        for (int i = 0; i < MAX_NODES; i++) adj_head[i] = MAX_EDGES;
        arc_total = 0;
        arc_dropped = 1'b0;
    endfunction

    // Iterative Tarjan search; returns the number of components found.
    function automatic int count_components(int n);
        int stamp, comps, sp, fp, v, e, w, y, p;
        stamp = 0;
        comps = 0;
        sp = 0;
        fp = 0;
        for (int i = 0; i < MAX_NODES; i++) begin
            disc[i] = 0;
            stacked[i] = 1'b0;
        end
        for (int r = 0; r < n; r++) begin
            if (disc[r] != 0) continue;
            stamp++;
            disc[r] = stamp;
            low[r] = stamp;
            stacked[r] = 1'b1;
            tarjan_stack[sp++] = r;
            frame_node[fp] = r;
            frame_arc[fp] = adj_head[r];
            fp++;
            while (fp > 0) begin
                v = frame_node[fp-1];
                e = frame_arc[fp-1];
                if (e < MAX_EDGES) begin
                    w = arc_to[e];
                    frame_arc[fp-1] = arc_next[e];
                    if (w >= n) continue;
                    if (disc[w] == 0) begin
                        stamp++;
                        disc[w] = stamp;
                        low[w] = stamp;
                        stacked[w] = 1'b1;
                        if (sp < MAX_NODES) tarjan_stack[sp++] = w;
                        if (fp < MAX_NODES) begin
                            frame_node[fp] = w;
                            frame_arc[fp] = adj_head[w];
                            fp++;
                        end
                    end else if (stacked[w] && disc[w] < low[v]) begin
                        low[v] = disc[w];
                    end
                end else begin
                    fp--;
                    if (low[v] == disc[v]) begin
                        y = -1;
                        while (sp > 0 && y != v) begin
                            y = tarjan_stack[--sp];
                            comp_of[y] = comps;
                            stacked[y] = 1'b0;
                        end
                        comps++;
                    end
                    if (fp > 0) begin
                        p = frame_node[fp-1];
                        if (low[v] < low[p]) low[p] = low[v];
                    end
                end
            end
        end
        return comps;
    endfunction

    // Applies one accepted item to the predictor and queues any answer.
    function automatic void predict_item(t_in_item item);
        int n, s, d, comps, no_in, no_out, need;
        t_out_item ans;
        n = live_nodes();
        if (item.func == FUNC_ADD) begin
            s = item.src_node;
            d = item.dst_node;
            if (s == 0 || d == 0 || s > n || d > n || arc_total >= MAX_EDGES) begin
                arc_dropped = 1'b1;
            end else begin
                arc_from[arc_total] = s - 1;
                arc_to[arc_total] = d - 1;
                arc_next[arc_total] = adj_head[s-1];
                adj_head[s-1] = arc_total;
                arc_total++;
            end
            return;
        end
        comps = count_components(n);
        for (int i = 0; i < MAX_NODES; i++) begin
            comp_in[i] = 1'b0;
            comp_out[i] = 1'b0;
        end
        for (int k = 0; k < arc_total; k++) begin
            if (arc_from[k] >= n || arc_to[k] >= n) continue;
            if (comp_of[arc_from[k]] != comp_of[arc_to[k]]) begin
                comp_in[comp_of[arc_to[k]]] = 1'b1;
                comp_out[comp_of[arc_from[k]]] = 1'b1;
            end
        end
        no_in = 0;
        no_out = 0;
        for (int c = 0; c < comps; c++) begin
            if (!comp_in[c]) no_in++;
            if (!comp_out[c]) no_out++;
        end
        need = (comps <= 1) ? 0 : ((no_in > no_out) ? no_in : no_out);
        ans.edges_needed = need[10:0];
        ans.component_count = comps[10:0];
        ans.dropped_edges = arc_dropped;
        answer_queue.insert(answer_queue.size(), ans);
        forget_graph();
    endfunction

    // ------------------------------------------------------------------
    // Driver: sends queued items in bursts with random gaps in between.
    // ------------------------------------------------------------------
    int burst_left = 8;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_item(i_in_data);
                void'(send_queue.pop_front());
            end
            // Hold the current item until the block takes it.
            if (!(i_in_valid && !o_in_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (send_queue.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= send_queue[0];
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        // A third of the bursts run straight into the next.
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: the receiver stalls on its own pattern and checks answers.
    // ------------------------------------------------------------------
    int          stall_mode = 0;
    logic [15:0] stall_bits = 16'hACE1;

    always @(posedge i_clk) begin
        if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 3);
        stall_bits = {stall_bits[14:0], stall_bits[15] ^ stall_bits[13] ^
                      stall_bits[12] ^ stall_bits[10]};
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= stall_bits[0];
            2: i_out_ready <= (stall_bits[1:0] == 2'b00);
            default: i_out_ready <= ($urandom_range(0, 9) != 0);
        endcase
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answer_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p",
                         $time, o_out_data);
                error_count++;
            end else begin
                t_out_item want;
                want = answer_queue.pop_front();
                if (o_out_data.edges_needed !== want.edges_needed) begin
                    $display("%0t: edges_needed mismatch, expected %0d, actual %0d",
                             $time, want.edges_needed, o_out_data.edges_needed);
                    error_count++;
                end
                if (o_out_data.component_count !== want.component_count) begin
                    $display("%0t: component_count mismatch, expected %0d, actual %0d",
                             $time, want.component_count, o_out_data.component_count);
                    error_count++;
                end
                if (o_out_data.dropped_edges !== want.dropped_edges) begin
                    $display("%0t: dropped_edges mismatch, expected %0b, actual %0b",
                             $time, want.dropped_edges, o_out_data.dropped_edges);
                    error_count++;
                end
            end
        end
    end

    // The run is bounded by a cycle counter in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_edge(int s, int d);
        t_in_item item;
        item.func = FUNC_ADD;
        item.src_node = s[10:0];
        item.dst_node = d[10:0];
        send_queue.insert(send_queue.size(), item);
        items_queued++;
    endtask

    task automatic queue_run();
        t_in_item item;
        item.func = FUNC_RUN;
        item.src_node = $urandom_range(0, 2047);
        item.dst_node = $urandom_range(0, 2047);
        send_queue.insert(send_queue.size(), item);
        items_queued++;
    endtask

    // Waits until every item is sent and every answer is back, then lets an
    // edge load or the clearing sweep finish inside the block.
    task automatic drain();
        while (send_queue.size() > 0 || answer_queue.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the node count while the block is idle.
    task automatic set_node_count(int value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value[10:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        nodes_cfg = value[10:0];
        i_cfg_valid <= 1'b0;
    endtask

    // Random edges over 1..n with a few ids out of range mixed in.
    task automatic queue_graph(int n, int edges);
        int top;
        top = (n < 1) ? 1 : n;
        for (int k = 0; k < edges; k++) begin
            if ($urandom_range(0, 15) == 0)
                queue_edge($urandom_range(0, 2047), $urandom_range(0, 2047));
            else
                queue_edge($urandom_range(1, top), $urandom_range(1, top));
        end
        queue_run();
    endtask

    initial begin
        int n;
        nodes_cfg = 11'd1;
        forget_graph();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Reset value of one node: empty run, self loop,
        // and an edge to a node that does not exist.
        queue_run();
        queue_edge(1, 1);
        queue_edge(2, 1);
        queue_run();

        // A node count above the capacity saturates to the full node range.
        set_node_count(2047);
        queue_edge(1, 1024);
        queue_edge(1024, 1);
        queue_edge(0, 5);
        queue_edge(1025, 3);
        queue_edge(3, 2047);
        queue_run();

        // A node count of zero is an empty graph and drops every edge.
        set_node_count(0);
        queue_edge(1, 1);
        queue_run();

        // A cycle with a tail and a separate pair: several components.
        set_node_count(6);
        queue_edge(1, 2);
        queue_edge(2, 3);
        queue_edge(3, 1);
        queue_edge(3, 4);
        queue_edge(5, 6);
        queue_run();

        // Lowering the node count after loading hides the upper edges.
        queue_edge(1, 6);
        queue_edge(6, 1);
        queue_edge(2, 5);
        set_node_count(3);
        queue_run();

        // Random part: mostly small graphs, a few at the full node range.
        while (items_queued < 750) begin
            case ($urandom_range(0, 19))
                0:       n = 1024;
                1:       n = 2047;
                2:       n = 0;
                3:       n = $urandom_range(100, 300);
                default: n = $urandom_range(1, 14);
            endcase
            set_node_count(n);
            repeat ($urandom_range(1, 3)) queue_graph(n, $urandom_range(0, 30));
            if ($urandom_range(0, 4) == 0) begin
                for (int k = 0; k < 12; k++)
                    queue_edge($urandom_range(1, 12), $urandom_range(1, 12));
                set_node_count($urandom_range(1, 12));
                queue_run();
            end
        end

        drain();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sceu_pkg.sv
sv/scc_augment_edge_count_unit.sv
sv/sceu_checker.sv
sim/tb.sv
